// File: src/mtk_pkg.sv
// Shared types, constants and key tables for the multi-tap keypad entry block.
// No dependencies; every other file in src but mtk_fifo imports this package.
package mtk_pkg;

  localparam int KEY_ROWS    = 4;
  localparam int KEY_COLS    = 3;
  localparam int MAX_TAPS    = 5;
  localparam int KEY_COUNT   = KEY_ROWS * KEY_COLS;
  localparam int QUEUE_DEPTH = 2;

  localparam int MATRIX_W = 12;
  localparam int CHAR_W   = 7;
  localparam int TICK_W   = 16;
  localparam int KEY_W    = 4;
  localparam int POS_W    = 2;
  localparam int TAP_W    = 3;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

  // Characters per key and tap position, key index row*3+col.
  localparam logic [0:KEY_COUNT-1][0:MAX_TAPS-1][CHAR_W-1:0] CHAR_TABLE = '{
    '{7'h31, 7'h00, 7'h00, 7'h00, 7'h00},  // 1
    '{7'h32, 7'h41, 7'h42, 7'h43, 7'h00},  // 2 A B C
    '{7'h33, 7'h44, 7'h45, 7'h46, 7'h00},  // 3 D E F
    '{7'h34, 7'h47, 7'h48, 7'h49, 7'h00},  // 4 G H I
    '{7'h35, 7'h4A, 7'h4B, 7'h4C, 7'h00},  // 5 J K L
    '{7'h36, 7'h4D, 7'h4E, 7'h4F, 7'h00},  // 6 M N O
    '{7'h37, 7'h50, 7'h51, 7'h52, 7'h53},  // 7 P Q R S
    '{7'h38, 7'h54, 7'h55, 7'h56, 7'h00},  // 8 T U V
    '{7'h39, 7'h57, 7'h58, 7'h59, 7'h5A},  // 9 W X Y Z
    '{7'h2A, 7'h00, 7'h00, 7'h00, 7'h00},  // *
    '{7'h30, 7'h20, 7'h7C, 7'h00, 7'h00},  // 0 space bar
    '{7'h23, 7'h00, 7'h00, 7'h00, 7'h00}   // #
  };

  localparam logic [0:KEY_COUNT-1][TAP_W-1:0] MODE_COUNT = '{
    3'd1, 3'd4, 3'd4,
    3'd4, 3'd4, 3'd4,
    3'd5, 3'd4, 3'd5,
    3'd1, 3'd3, 3'd1
  };

  // Classified request passed from the front to the back.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [KEY_W-1:0] key;
  } pick_t;

  typedef struct packed {
    logic [CHAR_W-1:0] preview_char;
    logic              commit;
    logic [CHAR_W-1:0] commit_char;
  } result_t;

endpackage

// File: src/multi_tap_keypad_entry.sv
// Multi-tap keypad entry: one matrix snapshot in, one preview/commit result out.
// A request waits in the mid queue; its result waits in the result queue.
// Throughput: one request per cycle while the result queue has room, set by the back end.
// Queues of QUEUE_DEPTH entries part the front, the back and the result side.
// Synchronous reset empties both queues, clears the session and sets the timeout to 1000.
// Depends on mtk_pkg, mtk_front, mtk_fifo and mtk_back.
module multi_tap_keypad_entry
  import mtk_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TICK_W-1:0]   tap_timeout_ticks,
  input  logic                push,
  output logic                full,
  input  logic [MATRIX_W-1:0] key_matrix,
  output logic                empty,
  input  logic                pop,
  output logic [CHAR_W-1:0]   preview_char,
  output logic                commit,
  output logic [CHAR_W-1:0]   commit_char
);

  pick_t   front_pick, mid_pick;
  logic    mid_empty, mid_pop;
  logic    res_full, res_push;
  result_t back_result, res_head;

  assign cfg_ready = 1'b1;

  mtk_front u_front (
    .key_matrix (key_matrix),
    .pick       (front_pick)
  );

  mtk_fifo #(
    .WIDTH ($bits(pick_t)),
    .DEPTH (QUEUE_DEPTH_P)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_pick),
    .full    (full),
    .pop     (mid_pop),
    .rd_data (mid_pick),
    .empty   (mid_empty)
  );

  mtk_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid),
    .cfg_data   (tap_timeout_ticks),
    .in_empty   (mid_empty),
    .in_pick    (mid_pick),
    .in_pop     (mid_pop),
    .out_full   (res_full),
    .out_push   (res_push),
    .out_result (back_result)
  );

  mtk_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH_P)
  ) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (back_result),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_head),
    .empty   (empty)
  );

  assign preview_char = res_head.preview_char;
  assign commit       = res_head.commit;
  assign commit_char  = res_head.commit_char;

endmodule

// File: src/mtk_fifo.sv
// Small synchronous queue of registers, one write and one read port.
// Depends on nothing; used between the front and back and at the result side.
module mtk_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: src/mtk_front.sv
// Front end: picks the first pressed key, column by column, row by row.
// Depends on mtk_pkg for the matrix geometry and the pick_t request type.
module mtk_front
  import mtk_pkg::*;
(
  input  logic [MATRIX_W-1:0] key_matrix,
  output pick_t               pick
);

  always_comb begin
    pick = '0;
    for (int c = 0; c < KEY_COLS; c++) begin
      for (int r = 0; r < KEY_ROWS; r++) begin
        if (!pick.found && key_matrix[r * KEY_COLS + c]) begin
          pick.found = 1'b1;
          pick.row   = POS_W'(r);
          pick.col   = POS_W'(c);
          pick.key   = KEY_W'(r * KEY_COLS + c);
        end
      end
    end
  end

endmodule

// File: src/mtk_back.sv
// Back end: session state, tap cycling, timeout and commit of one request a cycle while not stalled.
// Depends on mtk_pkg for the key tables, pick_t and result_t.
module mtk_back
  import mtk_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_data,
  input  logic              in_empty,
  input  pick_t             in_pick,
  output logic              in_pop,
  input  logic              out_full,
  output logic              out_push,
  output result_t           out_result
);

  logic [TICK_W-1:0] timeout_ticks;
  logic [POS_W-1:0]  last_row, last_row_next;
  logic [POS_W-1:0]  last_col, last_col_next;
  logic              have_last, have_last_next;
  logic [TAP_W-1:0]  tap_index, tap_index_next;
  logic              accept_press, accept_press_next;
  logic [TICK_W-1:0] elapsed, elapsed_next;
  logic [CHAR_W-1:0] shown_char, shown_char_next;

  logic              step;
  logic              committed;
  logic [TAP_W-1:0]  modes;
  logic [TAP_W-1:0]  tap_clamped;
  logic [CHAR_W-1:0] value;
  logic [POS_W-1:0]  sess_row, sess_col;

  assign step     = !in_empty && !out_full;
  assign in_pop   = step;
  assign out_push = step;

  assign modes       = MODE_COUNT[in_pick.key];
  assign tap_clamped = (tap_index >= modes) ? '0 : tap_index;
  assign value       = CHAR_TABLE[in_pick.key][tap_clamped];
  assign sess_row    = have_last ? last_row : in_pick.row;
  assign sess_col    = have_last ? last_col : in_pick.col;

  always_comb begin
    last_row_next     = last_row;
    last_col_next     = last_col;
    have_last_next    = have_last;
    tap_index_next    = tap_index;
    accept_press_next = accept_press;
    elapsed_next      = elapsed;
    shown_char_next   = shown_char;
    committed         = 1'b0;

    if (elapsed >= timeout_ticks) begin
      committed = 1'b1;
    end else if (in_pick.found) begin
      if (accept_press) begin
        if (in_pick.row == sess_row && in_pick.col == sess_col) begin
          last_row_next     = sess_row;
          last_col_next     = sess_col;
          have_last_next    = 1'b1;
          shown_char_next   = value;
          tap_index_next    = (tap_clamped + 1'b1 == modes) ? '0 : tap_clamped + 1'b1;
          elapsed_next      = '0;
          accept_press_next = 1'b0;
        end else begin
          // different key: end the session only
          committed = 1'b1;
        end
      end else begin
        // held key still drops a stale tap index
        tap_index_next = tap_clamped;
      end
    end else begin
      accept_press_next = 1'b1;
    end

    if (committed) begin
      last_row_next     = '0;
      last_col_next     = '0;
      have_last_next    = 1'b0;
      tap_index_next    = '0;
      accept_press_next = 1'b1;
      elapsed_next      = '0;
      shown_char_next   = '0;
    end else if (elapsed_next != TICK_MAX) begin
      elapsed_next = elapsed_next + 1'b1;
    end

    out_result.preview_char = shown_char_next;
    out_result.commit       = committed;
    out_result.commit_char  = committed ? shown_char : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      last_row      <= '0;
      last_col      <= '0;
      have_last     <= 1'b0;
      tap_index     <= '0;
      accept_press  <= 1'b1;
      elapsed       <= '0;
      shown_char    <= '0;
    end else begin
      if (cfg_we) begin
        timeout_ticks <= cfg_data;
      end
      if (step) begin
        last_row     <= last_row_next;
        last_col     <= last_col_next;
        have_last    <= have_last_next;
        tap_index    <= tap_index_next;
        accept_press <= accept_press_next;
        elapsed      <= elapsed_next;
        shown_char   <= shown_char_next;
      end
    end
  end

endmodule

// File: tb/sv/multi_tap_keypad_entry_tb.sv
// Self-checking testbench for multi_tap_keypad_entry: directed and random key matrix ticks,
// checked against an in-bench model of the multi-tap session logic.
// Depends on mtk_pkg and the multi_tap_keypad_entry RTL.
module multi_tap_keypad_entry_tb;
  import mtk_pkg::*;

  localparam int WATCHDOG_CYCLES = 4000;
  localparam int RANDOM_TICKS = 800;

  typedef struct {
    logic [MATRIX_W-1:0] matrix;
    bit                  drain;
  } tick_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [TICK_W-1:0]   tap_timeout_ticks = '0;
  logic                push = 1'b0;
  logic                full;
  logic [MATRIX_W-1:0] key_matrix = '0;
  logic                empty;
  logic                pop = 1'b0;
  logic [CHAR_W-1:0]   preview_char;
  logic                commit;
  logic [CHAR_W-1:0]   commit_char;

  multi_tap_keypad_entry i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .tap_timeout_ticks (tap_timeout_ticks),
    .push              (push),
    .full              (full),
    .key_matrix        (key_matrix),
    .empty             (empty),
    .pop               (pop),
    .preview_char      (preview_char),
    .commit            (commit),
    .commit_char       (commit_char)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Characters of each key in tap order, key index row*3+col; the length is the mode count.
  string key_text [KEY_COUNT] = '{"1", "2ABC", "3DEF", "4GHI", "5JKL", "6MNO",
                                  "7PQRS", "8TUV", "9WXYZ", "*", "0 |", "#"};

  // Session model state
  logic [TICK_W-1:0] timeout_ticks;
  logic [POS_W-1:0]  sess_row;
  logic [POS_W-1:0]  sess_col;
  bit                in_session;
  logic [TAP_W-1:0]  tap_pos;
  bit                release_seen;
  logic [TICK_W-1:0] idle_ticks;
  logic [CHAR_W-1:0] shown;

  tick_t   tick_queue[$];
  result_t predicted_entries[$];

  bit req_taken = 1'b0;
  bit res_taken = 1'b0;
  int gap_left = 0;
  int pop_wait = 0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  int idle_run = 0;
  int errors = 0;
  int ticks_sent = 0;
  int commits_seen = 0;
  int cfg_writes = 0;

  function automatic void clear_session();
    sess_row     = '0;
    sess_col     = '0;
    in_session   = 1'b0;
    tap_pos      = '0;
    release_seen = 1'b1;
    idle_ticks   = '0;
    shown        = '0;
  endfunction

  // Advance the session by one tick and return the entry it shows.
  function automatic result_t next_entry(logic [MATRIX_W-1:0] m);
    result_t r;
    bit      hit;
    int      row;
    int      col;
    int      key;
    int      modes;
    logic [CHAR_W-1:0] ch;
    r   = '0;
    hit = 1'b0;
    row = 0;
    col = 0;
    if (idle_ticks >= timeout_ticks) begin
      r.commit = 1'b1;
      r.commit_char = shown;
      clear_session();
    end else begin
      // scan column by column, top row first
      for (int c = 0; c < KEY_COLS; c++) begin
        for (int rr = 0; rr < KEY_ROWS; rr++) begin
          if (!hit && m[rr*KEY_COLS + c]) begin
            hit = 1'b1;
            row = rr;
            col = c;
          end
        end
      end
      if (hit) begin
        key   = row*KEY_COLS + col;
        modes = key_text[key].len();
        if (tap_pos >= modes) tap_pos = '0;
        ch = CHAR_W'(key_text[key][tap_pos]);
        if (release_seen) begin
          if (!in_session) begin
            sess_row   = POS_W'(row);
            sess_col   = POS_W'(col);
            in_session = 1'b1;
          end
          if (row == sess_row && col == sess_col) begin
            shown        = ch;
            tap_pos      = TAP_W'((int'(tap_pos) + 1) % modes);
            idle_ticks   = '0;
            release_seen = 1'b0;
          end else begin
            r.commit = 1'b1;
            r.commit_char = shown;
            clear_session();
          end
        end
      end else begin
        release_seen = 1'b1;
      end
      if (!r.commit && idle_ticks != TICK_MAX) idle_ticks = idle_ticks + 1'b1;
    end
    r.preview_char = shown;
    return r;
  endfunction

  function automatic void report_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Monitor: sample handshakes, run the model, check results, watch for a hang.
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      req_taken = 1'b0;
      res_taken = 1'b0;
      idle_run  = 0;
    end else begin
      req_taken = push && !full;
      res_taken = pop && !empty;
      if (cfg_valid && cfg_ready) timeout_ticks = tap_timeout_ticks;
      if (res_taken) begin
        if (predicted_entries.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h/%0b/%0h",
                   $time, preview_char, commit, commit_char);
          errors++;
        end else begin
          want = predicted_entries.pop_front();
          report_field("preview_char", want.preview_char, preview_char);
          report_field("commit", want.commit, commit);
          report_field("commit_char", want.commit_char, commit_char);
          if (commit) commits_seen++;
        end
      end
      if (req_taken) predicted_entries.push_back(next_entry(key_matrix));
      if (req_taken || res_taken || (cfg_valid && cfg_ready)) idle_run = 0;
      else idle_run++;
      if (idle_run >= WATCHDOG_CYCLES) begin
        $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Driver: present queued ticks with random gaps, holding a draining tick back.
  always @(negedge clk) begin : driver
    bit    nxt;
    tick_t t;
    if (!rst) begin
      nxt = push && !req_taken;
      if (!nxt) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (tick_queue.size() != 0 &&
                     !(tick_queue[0].drain && predicted_entries.size() != 0)) begin
          t = tick_queue.pop_front();
          key_matrix <= t.matrix;
          nxt = 1'b1;
          if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
          gap_left = send_steady ? 0 : $urandom_range(0, 14);
        end
      end
      push <= nxt;
    end
  end

  // Result side: random stall after each result taken.
  always @(negedge clk) begin : sink
    if (!rst) begin
      if (res_taken) begin
        if ($urandom_range(0, 39) == 0) recv_steady = !recv_steady;
        pop_wait = recv_steady ? 0 : $urandom_range(0, 14);
      end
      if (pop_wait != 0) begin
        pop_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic queue_tick(input logic [MATRIX_W-1:0] m, input bit drain);
    tick_queue.push_back('{m, drain});
    ticks_sent++;
  endtask

  // Wait until no tick is queued, pushed or predicted, with the check repeated
  // so that a tick the driver takes on the same edge is never missed.
  task automatic wait_idle();
    int quiet;
    quiet = 0;
    while (quiet < 2) begin
      @(negedge clk);
      if (tick_queue.size() != 0 || push || predicted_entries.size() != 0) quiet = 0;
      else quiet++;
    end
  endtask

  task automatic write_timeout(input logic [TICK_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    tap_timeout_ticks <= v;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // One typing session on a random key: taps with holds and releases, some noise,
  // and sometimes a quiet stretch long enough to run out the timeout.
  task automatic add_session(input int t);
    logic [MATRIX_W-1:0] key_bit;
    int taps;
    key_bit = 12'b1 << $urandom_range(0, KEY_COUNT-1);
    taps = $urandom_range(1, 6);
    for (int i = 0; i < taps; i++) begin
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 15))
          0:       queue_tick(MATRIX_W'($urandom), $urandom_range(0, 199) == 0);
          1, 2:    queue_tick(key_bit | MATRIX_W'($urandom), 1'b0);
          default: queue_tick(key_bit, $urandom_range(0, 199) == 0);
        endcase
      end
      repeat ($urandom_range(0, 2)) begin
        if ($urandom_range(0, 9) == 0) queue_tick(MATRIX_W'($urandom), 1'b0);
        else queue_tick('0, 1'b0);
      end
    end
    if (t <= 40 && $urandom_range(0, 2) == 0)
      repeat (t + $urandom_range(0, 2)) queue_tick('0, 1'b0);
  endtask

  initial begin : stimulus
    // bit row*3+col per key: 1=001 2=002 7=040 8=080 9=100 5=010 *=200 0=400 #=800
    logic [MATRIX_W-1:0] opening [26] = '{
      12'h000, 12'h002, 12'h000, 12'h002, 12'h002, 12'h000, 12'h002, 12'h000,
      12'h002, 12'h000, 12'h002, 12'h040, 12'h040, 12'h000, 12'h040, 12'h000,
      12'h040, 12'h000, 12'h040, 12'h041, 12'h000, 12'h040, 12'hFFF, 12'h800,
      12'h000, 12'h400};
    logic [MATRIX_W-1:0] no_wait [5] = '{12'h000, 12'h002, 12'h000, 12'hFFF, 12'h800};
    logic [MATRIX_W-1:0] one_tick [6] = '{12'h002, 12'h000, 12'h002, 12'h002, 12'h000,
                                           12'h080};
    logic [MATRIX_W-1:0] long_wait [10] = '{12'h100, 12'h000, 12'h100, 12'h000, 12'h100,
                                            12'h000, 12'h100, 12'h000, 12'h100, 12'h010};
    int budget;
    int t;
    int start_count;
    timeout_ticks = TIMEOUT_RESET;
    clear_session();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset timeout: tap wrap, held key, key change, stale tap index
    foreach (opening[i]) queue_tick(opening[i], i == 11);
    write_timeout('0);
    foreach (no_wait[i]) queue_tick(no_wait[i], 1'b0);
    write_timeout(16'd1);
    foreach (one_tick[i]) queue_tick(one_tick[i], 1'b0);
    write_timeout(TICK_MAX);
    foreach (long_wait[i]) queue_tick(long_wait[i], 1'b0);

    start_count = ticks_sent;
    for (int p = 0; p < 7; p++) begin
      case (p)
        0:       t = 1;
        1:       t = $urandom_range(2, 8);
        2:       t = $urandom_range(9, 40);
        3:       t = TICK_MAX;
        4:       t = 0;
        5:       t = TIMEOUT_RESET;
        default: t = $urandom_range(2, 25);
      endcase
      write_timeout(TICK_W'(t));
      // hold the zero and the long timeouts to short runs
      budget = (t == 0 || t > 40) ? RANDOM_TICKS / 12 : RANDOM_TICKS / 5;
      budget = ticks_sent + budget;
      while (ticks_sent < budget) add_session(t);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Ran %0d ticks (%0d random) over %0d timeout settings, %0d commits checked",
             ticks_sent, ticks_sent - start_count, cfg_writes, commits_seen);
    $display("Timeouts covered: zero, one, reset value, maximum and several small values");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
